>>> design/b64d_pkg.sv
// Package for the base64 text decoder: character codes, queue entry type and
// the alphabet lookup function. Depends on nothing; used by every module.
package b64d_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  // One decoded group: bytes are high aligned in data, nbytes of them valid.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nbytes;
    logic        pad;
  } b64d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_fifo_status_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] ch);
    logic [7:0] diff;
    logic [5:0] res;
    diff = 8'h00;
    res  = 6'd0;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      diff = ch - CHAR_UPPER_A;
      res  = diff[5:0];
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      diff = ch - CHAR_LOWER_A;
      res  = SEXTET_LOWER_BASE + diff[5:0];
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      diff = ch - CHAR_DIGIT_0;
      res  = SEXTET_DIGIT_BASE + diff[5:0];
    end else if (ch == CHAR_PLUS) begin
      res = SEXTET_PLUS;
    end else if (ch == CHAR_SLASH) begin
      res = SEXTET_SLASH;
    end
    return res;
  endfunction

endpackage

>>> design/b64d_front.sv
// Front end of the base64 decoder: accepts characters, classifies them and
// keeps the sextet accumulator. Depends on b64d_pkg.
module b64d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                start_text_i,
  input  logic                q_full_i,
  output logic                push_o,
  output b64d_pkg::b64d_job_t job_o
);
  import b64d_pkg::*;

  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stop_q, stop_d;
  logic        accept;
  logic [17:0] eff_acc;
  logic [1:0]  eff_cnt;
  logic        eff_stop;
  logic [5:0]  sext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign eff_acc    = start_text_i ? 18'd0 : acc_q;
  assign eff_cnt    = start_text_i ? 2'd0 : cnt_q;
  assign eff_stop   = start_text_i ? 1'b0 : stop_q;
  assign sext       = sextet_of(char_code_i);

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      acc_d  = eff_acc;
      cnt_d  = eff_cnt;
      stop_d = eff_stop;
      if (!eff_stop && char_code_i != CHAR_CR && char_code_i != CHAR_LF) begin
        if (char_code_i == CHAR_PAD) begin
          stop_d  = 1'b1;
          job_o.pad = 1'b1;
          if (eff_cnt == 2'd3) begin
            push_o       = 1'b1;
            job_o.data   = {eff_acc, 6'd0};
            job_o.nbytes = 2'd2;
          end else if (eff_cnt == 2'd2) begin
            push_o       = 1'b1;
            job_o.data   = {eff_acc[11:0], 12'd0};
            job_o.nbytes = 2'd1;
          end
        end else if (eff_cnt == 2'd3) begin
          push_o       = 1'b1;
          job_o.data   = {eff_acc, sext};
          job_o.nbytes = 2'd3;
          acc_d        = 18'd0;
          cnt_d        = 2'd0;
        end else begin
          acc_d = {eff_acc[11:0], sext};
          cnt_d = eff_cnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 18'd0;
      cnt_q  <= 2'd0;
      stop_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

>>> design/b64d_fifo.sv
// Short queue of decoded groups between front and back end of the decoder.
// Depends on b64d_pkg.
module b64d_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  b64d_pkg::b64d_job_t         push_job_i,
  input  logic                        pop_i,
  output b64d_pkg::b64d_job_t         pop_job_o,
  output b64d_pkg::b64d_fifo_status_t status_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  b64d_job_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == DepthCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push   = push_i && !status_o.full;
  assign do_pop    = pop_i && !status_o.empty;
  assign pop_job_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + PtrOne;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + PtrOne;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntOne;
        2'b01:   cnt_q <= cnt_q - CntOne;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> design/b64d_back.sv
// Back end of the decoder: takes decoded groups from the queue and sends
// their bytes one beat at a time from an output register. Depends on b64d_pkg.
module b64d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b64d_pkg::b64d_job_t         job_i,
  input  b64d_pkg::b64d_fifo_status_t q_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  data_byte_o,
  output logic                        last_of_run_o,
  output logic                        padding_end_o
);
  import b64d_pkg::*;

  logic        busy_q;
  logic [23:0] data_q;
  logic [1:0]  rem_q;
  logic        pad_q;
  logic        beat;
  logic        free;

  assign beat          = busy_q && out_ready_i;
  // The register frees up when empty or when its final byte leaves now.
  assign free          = !busy_q || (beat && rem_q == 2'd1);
  assign pop_o         = free && !q_status_i.empty;
  assign out_valid_o   = busy_q;
  assign data_byte_o   = data_q[23:16];
  assign last_of_run_o = (rem_q == 2'd1);
  assign padding_end_o = pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      rem_q  <= job_i.nbytes;
    end else if (free) begin
      busy_q <= 1'b0;
    end else if (beat) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= job_i.data;
      pad_q  <= job_i.pad;
    end else if (beat) begin
      data_q <= {data_q[15:0], 8'd0};
    end
  end

endmodule

>>> design/base64_text_decoder_core.sv
// Base64 text decoder, top level. A completed group passes the queue and the
// back end output register. Throughput: one character per cycle in, stalled
// only while the group queue is full; one byte per cycle out while the
// consumer is ready, set by the back end serializer.
// Reset (rst_ni low, asynchronous) empties the queue, drops any pending bytes
// and clears the accumulator, sextet count and stop flag.
module base64_text_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tuser_i,   // [0] start_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // last_of_run
  output logic       m_axis_tuser_o    // [0] padding_end
);
  import b64d_pkg::*;

  // The front end classifies each character beat and, when a group or a
  // padded tail is complete, pushes one entry of up to three bytes.
  b64d_job_t         push_job;
  b64d_job_t         pop_job;
  b64d_fifo_status_t q_status;
  logic              push;
  logic              pop;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .char_code_i  (s_axis_tdata_i),
    .start_text_i (s_axis_tuser_i),
    .q_full_i     (q_status.full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // The queue lets the front keep taking characters while the back end
  // is stalled by the downstream consumer.
  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .status_o   (q_status)
  );

  // The back end sends the bytes of each entry, marking the final one.
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (pop_job),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .data_byte_o   (m_axis_tdata_o),
    .last_of_run_o (m_axis_tlast_o),
    .padding_end_o (m_axis_tuser_o)
  );

  // An entry is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("group queue overflow");

  // An entry is never taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("group queue underflow");

  // A byte that is not the final one of its entry is always followed by more.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("byte run cut short");

endmodule

>>> dv/base64_text_decoder_checker.sv
`timescale 1ns / 100ps
// Checker for the base64 text decoder: watches both stream channels, predicts
// the decoded bytes of every accepted character and compares them with the
// bytes that leave the block. Depends on b64d_pkg for the character codes.
module base64_text_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // [7:0] char_code
  input  logic        s_tuser_i,    // [0] start_text
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,    // [7:0] data_byte
  input  logic        m_tlast_i,    // last_of_run
  input  logic        m_tuser_i,    // [0] padding_end
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import b64d_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       pad;
  } dec_byte_t;

  dec_byte_t   byte_forecast_q[$];
  logic [17:0] sextets_q;
  logic [1:0]  held_q;
  logic        stopped_q;
  int unsigned mismatch_count = 0;
  int unsigned outstanding    = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = outstanding;

  function automatic logic [5:0] sextet_value(input logic [7:0] ch);
    logic [7:0] off;
    off = 8'h00;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      off = ch - CHAR_UPPER_A;
      return off[5:0];
    end
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      off = ch - CHAR_LOWER_A;
      return SEXTET_LOWER_BASE + off[5:0];
    end
    if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      off = ch - CHAR_DIGIT_0;
      return SEXTET_DIGIT_BASE + off[5:0];
    end
    if (ch == CHAR_PLUS) return SEXTET_PLUS;
    if (ch == CHAR_SLASH) return SEXTET_SLASH;
    // Anything else outside the alphabet decodes as zero.
    return 6'd0;
  endfunction

  // Appends one predicted byte at the tail of the forecast.
  task automatic expect_byte(input logic [7:0] d, input logic l, input logic p);
    dec_byte_t b;
    b.data = d;
    b.last = l;
    b.pad  = p;
    byte_forecast_q.insert(byte_forecast_q.size(), b);
  endtask

  // Advances the predicted decoder state by one character and queues the
  // bytes it releases.
  task automatic decode_char(input logic [7:0] ch, input logic st);
    logic [23:0] group;
    if (st) begin
      sextets_q = '0;
      held_q    = '0;
      stopped_q = 1'b0;
    end
    if (stopped_q || ch == CHAR_CR || ch == CHAR_LF) return;
    if (ch == CHAR_PAD) begin
      // The pad ends the text; the held sextets keep their value.
      stopped_q = 1'b1;
      if (held_q == 2'd3) begin
        expect_byte(sextets_q[17:10], 1'b0, 1'b1);
        expect_byte(sextets_q[9:2], 1'b1, 1'b1);
      end else if (held_q == 2'd2) begin
        expect_byte(sextets_q[11:4], 1'b1, 1'b1);
      end
      return;
    end
    if (held_q == 2'd3) begin
      group = {sextets_q, sextet_value(ch)};
      expect_byte(group[23:16], 1'b0, 1'b0);
      expect_byte(group[15:8], 1'b0, 1'b0);
      expect_byte(group[7:0], 1'b1, 1'b0);
      sextets_q = '0;
      held_q    = '0;
    end else begin
      sextets_q = {sextets_q[11:0], sextet_value(ch)};
      held_q    = held_q + 2'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_byte_t want;
    if (!rst_ni) begin
      byte_forecast_q.delete();
      sextets_q   = '0;
      held_q      = '0;
      stopped_q   = 1'b0;
      outstanding = 0;
    end else begin
      // A byte leaving now always stems from an earlier character, so it is
      // matched before this edge's character is decoded.
      if (m_tvalid_i && m_tready_i) begin
        if (byte_forecast_q.size() == 0) begin
          $display("%0t: unexpected byte data %h last %b pad %b", $time,
                   m_tdata_i, m_tlast_i, m_tuser_i);
          mismatch_count++;
        end else begin
          want = byte_forecast_q.pop_front();
          if (want.data !== m_tdata_i || want.last !== m_tlast_i ||
              want.pad !== m_tuser_i) begin
            $display({"%0t: byte mismatch, expected data %h last %b pad %b, ",
                      "got data %h last %b pad %b"},
                     $time, want.data, want.last, want.pad,
                     m_tdata_i, m_tlast_i, m_tuser_i);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) decode_char(s_tdata_i, s_tuser_i);
      outstanding = byte_forecast_q.size();
    end
  end

endmodule

>>> dv/base64_text_decoder_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the base64 text decoder: clock, reset, character stimulus
// and output back pressure. Depends on b64d_pkg, the decoder core and the
// base64_text_decoder_checker module, which predicts and compares.
module base64_text_decoder_core_test;

  import b64d_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned ItemTarget    = 250;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [7:0]  s_data   = 8'h00;
  logic        s_user   = 1'b0;
  logic        m_ready  = 1'b1;
  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;
  wire         m_last;
  wire         m_user;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned chars_sent = 0;
  bit          quiet      = 1'b0;
  bit          gaps_on    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  base64_text_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  base64_text_decoder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tlast_i    (m_last),
    .m_tuser_i    (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Output back pressure: stall bursts between ready stretches, some of the
  // stretches long. No stalls once the run turns quiet.
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
          @(negedge clk_i);
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    int unsigned still_cycles;
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      still_cycles = 0;
    end else begin
      still_cycles++;
      if (still_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles, %0d bytes outstanding", $time,
                 still_cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return CHAR_UPPER_A + {2'b00, v};
    if (v < 6'd52) return CHAR_LOWER_A + {2'b00, v - 6'd26};
    if (v < 6'd62) return CHAR_DIGIT_0 + {2'b00, v - 6'd52};
    if (v == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // Presents one character and returns at the falling edge after its beat.
  // Called at a falling edge; valid stays high for a following character.
  task automatic send_char(input logic [7:0] ch, input logic st, input bit counted);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_user  <= st;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
    if (counted) chars_sent++;
  endtask

  // Holds the sender off until every predicted byte has left the block.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // One random text: a start flag, whole groups, a partial tail, stray line
  // breaks and noise, then a pad that stray characters may follow, or nothing.
  task automatic send_text();
    int unsigned groups;
    int unsigned tail;
    bit          first;
    logic [7:0]  ch;
    groups  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    tail    = $urandom_range(0, 3);
    first   = 1'b1;
    gaps_on = !quiet && ($urandom_range(0, 2) != 0);
    for (int unsigned i = 0; i < groups * 4 + tail; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, first, 1'b1);
        first = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) ch = 8'($urandom_range(0, 255));
      else ch = b64_char(6'($urandom_range(0, 63)));
      // A rare start flag in the middle of a text cuts the group short.
      send_char(ch, first || ($urandom_range(0, 24) == 0), 1'b1);
      first = 1'b0;
    end
    if ((tail >= 2 && $urandom_range(0, 3) != 0) || (tail < 2 && $urandom_range(0, 1) == 0)) begin
      send_char(CHAR_PAD, first, 1'b1);
      // Characters after the pad are dropped by the block.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  initial begin
    bit paused_mid;
    paused_mid = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Alphabet ends in one full group.
    gaps_on = 1'b1;
    send_char("A", 1'b1, 1'b1);
    send_char("Z", 1'b0, 1'b1);
    send_char("a", 1'b0, 1'b1);
    send_char("z", 1'b0, 1'b1);
    // Digits, plus and slash with line breaks mixed in.
    send_char("0", 1'b0, 1'b1);
    send_char(CHAR_CR, 1'b0, 1'b1);
    send_char("9", 1'b0, 1'b1);
    send_char(CHAR_LF, 1'b0, 1'b1);
    send_char("+", 1'b0, 1'b1);
    send_char("/", 1'b0, 1'b1);
    // Characters outside the alphabet, NUL and the high codes among them.
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b0, 1'b1);
    send_char(8'h80, 1'b0, 1'b1);
    send_char("-", 1'b0, 1'b1);
    // Pad with three sextets held, then a character dropped while stopped.
    send_char("Q", 1'b0, 1'b1);
    send_char("U", 1'b0, 1'b1);
    send_char("J", 1'b0, 1'b1);
    send_char(CHAR_PAD, 1'b0, 1'b1);
    send_char("x", 1'b0, 1'b1);
    // Pad with two, one and no sextets held.
    send_char("Q", 1'b1, 1'b1);
    send_char("U", 1'b0, 1'b1);
    send_char(CHAR_PAD, 1'b0, 1'b1);
    send_char("Q", 1'b1, 1'b1);
    send_char(CHAR_PAD, 1'b0, 1'b1);
    send_char(CHAR_PAD, 1'b1, 1'b1);
    // A trailing partial group that the next start flag throws away.
    send_char("B", 1'b1, 1'b1);
    send_char("C", 1'b0, 1'b1);
    wait_drained();

    while (chars_sent < ItemTarget) begin
      if (chars_sent >= ItemTarget - 40) quiet = 1'b1;
      if (!paused_mid && chars_sent >= ItemTarget / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      send_text();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_text_decoder_core.sv
dv/base64_text_decoder_checker.sv
dv/base64_text_decoder_core_test.sv
